// File: src/at3_pkg.sv
package at3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int IO_BITS       = 32;
  localparam int OP_BITS       = 4;
  localparam int IDX_BITS      = 4;
  localparam int ELEMS         = 9;
  localparam int CNT_BITS      = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_IDENT      = 4'd0,
    OP_WR_CUR     = 4'd1,
    OP_WR_OPR     = 4'd2,
    OP_MUL_R      = 4'd3,
    OP_MUL_L      = 4'd4,
    OP_TRANS      = 4'd5,
    OP_ROT        = 4'd6,
    OP_SCALE      = 4'd7,
    OP_ADD_TRANS  = 4'd8,
    OP_SCL_DIAG   = 4'd9,
    OP_INV        = 4'd10,
    OP_TRANSPOSE  = 4'd11,
    OP_SET_TRANS  = 4'd12,
    OP_SET_ROT    = 4'd13,
    OP_SET_SCALE  = 4'd14,
    OP_NONE       = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL,
    ST_DIAG,
    ST_ADJ,
    ST_DET,
    ST_CHECK,
    ST_DIV,
    ST_INV,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_MUL,
    PH_DIAG,
    PH_ADJ,
    PH_DET,
    PH_INV
  } phase_t;

  // Number of multiply-accumulate issues in each phase.
  localparam logic [CNT_BITS-1:0] LEN_MUL  = CNT_BITS'(27);
  localparam logic [CNT_BITS-1:0] LEN_DIAG = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] LEN_ADJ  = CNT_BITS'(18);
  localparam logic [CNT_BITS-1:0] LEN_DET  = CNT_BITS'(3);
  localparam logic [CNT_BITS-1:0] LEN_INV  = CNT_BITS'(9);

  typedef struct packed {
    logic                take;
    logic                pre;
    phase_t              phase;
    logic                issue;
    logic [CNT_BITS-1:0] cnt;
    logic                div_start;
    logic                set_singular;
    logic                commit;
    logic                load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic det_zero;
    logic div_done;
  } dp_stat_t;

  // Quotient by three for small counts, as a multiply by 11/32.
  function automatic logic [3:0] div3(input logic [CNT_BITS-1:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd11;
    return p[8:5];
  endfunction

  // Element pair {a, b} read for one product of an adjugate entry.
  function automatic logic [7:0] adj_pair(input logic [3:0] e, input logic t);
    logic [7:0] r;
    unique case (e)
      4'd0:    r = t ? {4'd7, 4'd5} : {4'd4, 4'd8};
      4'd1:    r = t ? {4'd1, 4'd8} : {4'd7, 4'd2};
      4'd2:    r = t ? {4'd4, 4'd2} : {4'd1, 4'd5};
      4'd3:    r = t ? {4'd3, 4'd8} : {4'd6, 4'd5};
      4'd4:    r = t ? {4'd6, 4'd2} : {4'd0, 4'd8};
      4'd5:    r = t ? {4'd0, 4'd5} : {4'd3, 4'd2};
      4'd6:    r = t ? {4'd6, 4'd4} : {4'd3, 4'd7};
      4'd7:    r = t ? {4'd0, 4'd7} : {4'd6, 4'd1};
      4'd8:    r = t ? {4'd3, 4'd1} : {4'd0, 4'd4};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/at3_ctl.sv
module at3_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  at3_pkg::dp_stat_t  stat,
  output at3_pkg::dp_cmd_t   cmd
);

  at3_pkg::state_t                  state_r, state_nxt;
  logic [at3_pkg::CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                             final_r, final_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [at3_pkg::CNT_BITS-1:0]     len;
  logic                             inv_first;

  always_comb begin
    unique case (state_r)
      at3_pkg::ST_MUL:  len = at3_pkg::LEN_MUL;
      at3_pkg::ST_DIAG: len = at3_pkg::LEN_DIAG;
      at3_pkg::ST_ADJ:  len = at3_pkg::LEN_ADJ;
      at3_pkg::ST_DET:  len = at3_pkg::LEN_DET;
      at3_pkg::ST_INV:  len = at3_pkg::LEN_INV;
      default:          len = '0;
    endcase
  end

  assign inv_first = (stat.op == at3_pkg::OP_INV) && !final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= at3_pkg::ST_IDLE;
      cnt_r       <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      at3_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = at3_pkg::ST_PRE;
          final_nxt = 1'b0;
        end
      end
      at3_pkg::ST_PRE: begin
        cnt_nxt = '0;
        unique case (stat.op)
          at3_pkg::OP_MUL_R, at3_pkg::OP_MUL_L, at3_pkg::OP_TRANS,
          at3_pkg::OP_ROT, at3_pkg::OP_SCALE: state_nxt = at3_pkg::ST_MUL;
          at3_pkg::OP_SCL_DIAG:             state_nxt = at3_pkg::ST_DIAG;
          default:                          state_nxt = at3_pkg::ST_ADJ;
        endcase
      end
      at3_pkg::ST_MUL, at3_pkg::ST_DIAG, at3_pkg::ST_ADJ,
      at3_pkg::ST_DET, at3_pkg::ST_INV: begin
        if (cnt_r == len) begin
          cnt_nxt = '0;
          unique case (state_r)
            at3_pkg::ST_MUL:  state_nxt = at3_pkg::ST_COMMIT;
            at3_pkg::ST_DIAG: state_nxt = at3_pkg::ST_ADJ;
            at3_pkg::ST_ADJ:  state_nxt = at3_pkg::ST_DET;
            at3_pkg::ST_DET:  state_nxt = at3_pkg::ST_CHECK;
            default:          state_nxt = at3_pkg::ST_COMMIT;
          endcase
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      at3_pkg::ST_CHECK: begin
        if (inv_first && !stat.det_zero) state_nxt = at3_pkg::ST_DIV;
        else                             state_nxt = at3_pkg::ST_OUT;
      end
      at3_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = at3_pkg::ST_INV;
      end
      at3_pkg::ST_COMMIT: begin
        final_nxt = 1'b1;
        state_nxt = at3_pkg::ST_ADJ;
      end
      at3_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt     = at3_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = at3_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd              = '0;
    cmd.cnt          = cnt_r;
    cmd.take         = (state_r == at3_pkg::ST_IDLE) && in_valid;
    cmd.pre          = (state_r == at3_pkg::ST_PRE);
    unique case (state_r)
      at3_pkg::ST_MUL:  cmd.phase = at3_pkg::PH_MUL;
      at3_pkg::ST_DIAG: cmd.phase = at3_pkg::PH_DIAG;
      at3_pkg::ST_ADJ:  cmd.phase = at3_pkg::PH_ADJ;
      at3_pkg::ST_DET:  cmd.phase = at3_pkg::PH_DET;
      at3_pkg::ST_INV:  cmd.phase = at3_pkg::PH_INV;
      default:          cmd.phase = at3_pkg::PH_NONE;
    endcase
    cmd.issue        = (cmd.phase != at3_pkg::PH_NONE) && (cnt_r < len);
    cmd.div_start    = (state_r == at3_pkg::ST_CHECK) && inv_first && !stat.det_zero;
    cmd.set_singular = (state_r == at3_pkg::ST_CHECK) && inv_first && stat.det_zero;
    cmd.commit       = (state_r == at3_pkg::ST_COMMIT);
    cmd.load_out     = (state_r == at3_pkg::ST_OUT) && (!out_valid_r || out_ready);
  end

  assign in_ready  = (state_r == at3_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_take_to_pre: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == at3_pkg::ST_PRE)
    else $error("accepted transaction did not start its setup step");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> cnt_r < len)
    else $error("multiply issued past the end of its phase");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwrote one not yet taken");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == at3_pkg::ST_DIV && !stat.div_done) |=> state_r == at3_pkg::ST_DIV)
    else $error("left the divide before the reciprocal was ready");

endmodule

// File: src/at3_dp.sv
module at3_dp #(
  parameter int FRAC_BITS = at3_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = at3_pkg::WORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  at3_pkg::dp_cmd_t                             cmd,
  output at3_pkg::dp_stat_t                            stat,
  input  logic [at3_pkg::OP_BITS-1:0]                  in_op,
  input  logic [at3_pkg::IDX_BITS-1:0]                 in_index,
  input  logic signed [at3_pkg::IO_BITS-1:0]           in_val_a,
  input  logic signed [at3_pkg::IO_BITS-1:0]           in_val_b,
  output logic [at3_pkg::ELEMS-1:0][at3_pkg::IO_BITS-1:0] out_elem,
  output logic [at3_pkg::IO_BITS-1:0]                  out_det,
  output logic                                         out_singular
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int IO  = at3_pkg::IO_BITS;
  localparam int PW  = 2 * W;
  localparam int AW  = 2 * W + 2;
  localparam int NW  = (((2 * F + 1) > W) ? (2 * F + 1) : W) + 1;
  localparam int DCW = $clog2(NW + 1);
  localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (F - 1);

  typedef logic signed [W-1:0] word_t;
  typedef enum logic [1:0] {DST_RES, DST_CUR, DST_ADJ, DST_DET} dst_t;
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       sub;
    dst_t       dst;
    logic [3:0] idx;
  } tag_t;

  function automatic word_t sat_a(input logic signed [AW-1:0] v);
    if (v[AW-1:W-1] == {(AW-W+1){v[AW-1]}}) return v[W-1:0];
    else if (v[AW-1])                        return {1'b1, {(W-1){1'b0}}};
    else                                     return {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [AW-1:0] ext_w(input word_t v);
    return {{(AW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [AW-1:0] ext_io(input logic signed [IO-1:0] v);
    return {{(AW-IO){v[IO-1]}}, v};
  endfunction

  function automatic logic [IO-1:0] sat_o(input word_t v);
    logic signed [AW-1:0] e;
    e = ext_w(v);
    if (e[AW-1:IO-1] == {(AW-IO+1){e[AW-1]}}) return e[IO-1:0];
    else if (e[AW-1])                          return {1'b1, {(IO-1){1'b0}}};
    else                                       return {1'b0, {(IO-1){1'b1}}};
  endfunction

  word_t cur_r [at3_pkg::ELEMS];
  word_t opr_r [at3_pkg::ELEMS];
  word_t pm_r  [at3_pkg::ELEMS];
  word_t adj_r [at3_pkg::ELEMS];
  word_t res_r [at3_pkg::ELEMS];
  word_t basic [at3_pkg::ELEMS];
  word_t det_r, rcp_r;

  at3_pkg::op_t                  op_r;
  logic [at3_pkg::IDX_BITS-1:0]  idx_r;
  logic signed [IO-1:0]          a_r, b_r;
  logic                          singular_r;

  word_t one_w, a_w, b_w, nb_w;

  assign one_w = sat_a({{(AW-1){1'b0}}, 1'b1} << F);
  assign a_w   = sat_a(ext_io(a_r));
  assign b_w   = sat_a(ext_io(b_r));
  assign nb_w  = sat_a(-ext_io(b_r));

  // Set-up matrix for translation, rotation and scaling.
  always_comb begin
    word_t d0, d1, o01, o10, t0, t1;
    d0 = one_w; d1 = one_w; o01 = '0; o10 = '0; t0 = '0; t1 = '0;
    unique case (op_r)
      at3_pkg::OP_TRANS, at3_pkg::OP_SET_TRANS: begin
        t0 = a_w; t1 = b_w;
      end
      at3_pkg::OP_ROT, at3_pkg::OP_SET_ROT: begin
        d0 = a_w; d1 = a_w; o01 = nb_w; o10 = b_w;
      end
      at3_pkg::OP_SCALE, at3_pkg::OP_SET_SCALE: begin
        d0 = a_w; d1 = b_w;
      end
      default: ;
    endcase
    basic[0] = d0;  basic[1] = o01; basic[2] = t0;
    basic[3] = o10; basic[4] = d1;  basic[5] = t1;
    basic[6] = '0;  basic[7] = '0;  basic[8] = one_w;
  end

  // Operand selection for the shared multiplier.
  word_t      opa, opb;
  tag_t       tag_nxt, tag_r;
  logic [3:0] mul_e, mul_i, ai, bi;
  logic [1:0] mul_t, mul_j;
  logic [at3_pkg::CNT_BITS-1:0] rem_t, rem_j;
  logic [7:0] pair;

  always_comb begin
    mul_e = at3_pkg::div3(cmd.cnt);
    rem_t = cmd.cnt - at3_pkg::CNT_BITS'(mul_e) * at3_pkg::CNT_BITS'(3);
    mul_t = rem_t[1:0];
    mul_i = at3_pkg::div3(at3_pkg::CNT_BITS'(mul_e));
    rem_j = at3_pkg::CNT_BITS'(mul_e) - at3_pkg::CNT_BITS'(mul_i) * at3_pkg::CNT_BITS'(3);
    mul_j = rem_j[1:0];
    ai    = 4'(mul_i * 4'd3 + 4'(mul_t));
    bi    = 4'(4'(mul_t) * 4'd3 + 4'(mul_j));
    pair  = at3_pkg::adj_pair(cmd.cnt[4:1], cmd.cnt[0]);
    opa   = '0;
    opb   = '0;
    tag_nxt       = '0;
    tag_nxt.valid = cmd.issue;
    unique case (cmd.phase)
      at3_pkg::PH_MUL: begin
        if (op_r == at3_pkg::OP_MUL_L) begin
          opa = opr_r[ai];
          opb = cur_r[bi];
        end else begin
          opa = cur_r[ai];
          opb = (op_r == at3_pkg::OP_MUL_R) ? opr_r[bi] : pm_r[bi];
        end
        tag_nxt.first = (mul_t == 2'd0);
        tag_nxt.last  = (mul_t == 2'd2);
        tag_nxt.dst   = DST_RES;
        tag_nxt.idx   = mul_e;
      end
      at3_pkg::PH_DIAG: begin
        opa = cmd.cnt[0] ? cur_r[4] : cur_r[0];
        opb = a_w;
        tag_nxt.first = 1'b1;
        tag_nxt.last  = 1'b1;
        tag_nxt.dst   = DST_CUR;
        tag_nxt.idx   = cmd.cnt[0] ? 4'd4 : 4'd0;
      end
      at3_pkg::PH_ADJ: begin
        opa = cur_r[pair[7:4]];
        opb = cur_r[pair[3:0]];
        tag_nxt.first = !cmd.cnt[0];
        tag_nxt.last  = cmd.cnt[0];
        tag_nxt.sub   = cmd.cnt[0];
        tag_nxt.dst   = DST_ADJ;
        tag_nxt.idx   = cmd.cnt[4:1];
      end
      at3_pkg::PH_DET: begin
        opa = cur_r[cmd.cnt[3:0]];
        opb = adj_r[4'(cmd.cnt[3:0] * 4'd3)];
        tag_nxt.first = (cmd.cnt == '0);
        tag_nxt.last  = (cmd.cnt == at3_pkg::CNT_BITS'(2));
        tag_nxt.dst   = DST_DET;
      end
      at3_pkg::PH_INV: begin
        opa = rcp_r;
        opb = adj_r[cmd.cnt[3:0]];
        tag_nxt.first = 1'b1;
        tag_nxt.last  = 1'b1;
        tag_nxt.dst   = DST_RES;
        tag_nxt.idx   = cmd.cnt[3:0];
      end
      default: ;
    endcase
  end

  // Multiplier stage, then accumulate and round.
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, base, sum;
  word_t                fixed;

  always_ff @(posedge clk) begin
    if (!rst_n) tag_r <= '0;
    else        tag_r <= tag_nxt;
    prod_r <= opa * opb;
    if (tag_r.valid) acc_r <= sum;
  end

  always_comb begin
    base  = tag_r.first ? '0 : acc_r;
    sum   = tag_r.sub ? base - {{(AW-PW){prod_r[PW-1]}}, prod_r}
                      : base + {{(AW-PW){prod_r[PW-1]}}, prod_r};
    fixed = sat_a((sum + HALF) >>> F);
  end

  logic wb;
  assign wb = tag_r.valid && tag_r.last;

  // Current matrix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < at3_pkg::ELEMS; k++)
        cur_r[k] <= (k == 0 || k == 4 || k == 8) ? one_w : '0;
    end else if (cmd.pre) begin
      unique case (op_r)
        at3_pkg::OP_IDENT, at3_pkg::OP_SET_TRANS,
        at3_pkg::OP_SET_ROT, at3_pkg::OP_SET_SCALE: begin
          for (int k = 0; k < at3_pkg::ELEMS; k++) cur_r[k] <= basic[k];
        end
        at3_pkg::OP_WR_CUR: begin
          if (idx_r < 4'd9) cur_r[idx_r] <= a_w;
        end
        at3_pkg::OP_ADD_TRANS: begin
          cur_r[2] <= sat_a(ext_w(cur_r[2]) + ext_w(a_w));
          cur_r[5] <= sat_a(ext_w(cur_r[5]) + ext_w(b_w));
        end
        at3_pkg::OP_TRANSPOSE: begin
          for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
              cur_r[r * 3 + c] <= cur_r[c * 3 + r];
        end
        default: ;
      endcase
    end else if (cmd.commit) begin
      for (int k = 0; k < at3_pkg::ELEMS; k++) cur_r[k] <= res_r[k];
    end else if (wb && tag_r.dst == DST_CUR) begin
      cur_r[tag_r.idx] <= fixed;
    end
  end

  // Operand and set-up matrices, product and adjugate stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < at3_pkg::ELEMS; k++) opr_r[k] <= '0;
    end else if (cmd.pre && op_r == at3_pkg::OP_WR_OPR && idx_r < 4'd9) begin
      opr_r[idx_r] <= a_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pre)
      for (int k = 0; k < at3_pkg::ELEMS; k++) pm_r[k] <= basic[k];
    if (wb && tag_r.dst == DST_RES) res_r[tag_r.idx] <= fixed;
    if (wb && tag_r.dst == DST_ADJ) adj_r[tag_r.idx] <= fixed;
    if (wb && tag_r.dst == DST_DET) det_r <= fixed;
  end

  // Transaction capture and singular flag.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= at3_pkg::op_t'(in_op);
      idx_r <= in_index;
      a_r   <= in_val_a;
      b_r   <= in_val_b;
    end
    if (!rst_n)                singular_r <= 1'b0;
    else if (cmd.take)         singular_r <= 1'b0;
    else if (cmd.set_singular) singular_r <= 1'b1;
  end

  // Restoring divider for the rounded reciprocal of the determinant.
  logic [W-1:0]   mag;
  logic [NW-1:0]  num_r, q_r;
  logic [W:0]     den_r, drem_r;
  logic [W+1:0]   trial;
  logic [DCW-1:0] dcnt_r;
  logic           busy_r, fin_r, neg_r;

  assign mag   = det_r[W-1] ? W'(-det_r) : W'(det_r);
  assign trial = {drem_r, num_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= busy_r && (dcnt_r == DCW'(1));
      if (cmd.div_start) busy_r <= 1'b1;
      else if (busy_r && dcnt_r == DCW'(1)) busy_r <= 1'b0;
    end
    if (cmd.div_start) begin
      num_r  <= (NW'(1) << (2 * F + 1)) + NW'(mag);
      den_r  <= {mag, 1'b0};
      drem_r <= '0;
      q_r    <= '0;
      dcnt_r <= DCW'(NW);
      neg_r  <= det_r[W-1];
    end else if (busy_r) begin
      num_r  <= num_r << 1;
      dcnt_r <= dcnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        drem_r <= W'(trial - {1'b0, den_r}) | ((W+1)'(0));
        q_r    <= {q_r[NW-2:0], 1'b1};
      end else begin
        drem_r <= trial[W:0];
        q_r    <= {q_r[NW-2:0], 1'b0};
      end
    end
    if (fin_r) begin
      if ((q_r >> (W - 1)) == '0) rcp_r <= neg_r ? -word_t'(q_r[W-1:0]) : word_t'(q_r[W-1:0]);
      else                        rcp_r <= neg_r ? {1'b1, {(W-1){1'b0}}}
                                                 : {1'b0, {(W-1){1'b1}}};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int k = 0; k < at3_pkg::ELEMS; k++) out_elem[k] <= sat_o(cur_r[k]);
      out_det      <= sat_o(det_r);
      out_singular <= singular_r;
    end
  end

  assign stat.op       = op_r;
  assign stat.det_zero = (det_r == '0);
  assign stat.div_done = fin_r;

endmodule

// File: src/affine_3x3_transform_unit.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_op, in_index, in_val_a, in_val_b
// result    out_valid / out_ready  out_e00 .. out_e22, out_determinant, out_singular
//
// One transaction is worked at a time on a single shared multiplier with a
// registered product, followed by the adjugate (18 products) and the
// determinant (3 products) of the new matrix. An invert also runs a
// bit-serial divide of width NW = max(2*FRAC_BITS+1, WORD_BITS)+1.
// Reset (rst_n low at a clock edge) loads the identity and a zero operand.
// A finished result waits in the output register; a new input transaction is
// taken meanwhile and only its own result stalls until the register is free.
module affine_3x3_transform_unit #(
  parameter int FRAC_BITS = at3_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = at3_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [at3_pkg::OP_BITS-1:0]         in_op,
  input  logic [at3_pkg::IDX_BITS-1:0]        in_index,
  input  logic signed [at3_pkg::IO_BITS-1:0]  in_val_a,
  input  logic signed [at3_pkg::IO_BITS-1:0]  in_val_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e00,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e01,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e02,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e10,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e11,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e12,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e20,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e21,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_e22,
  output logic signed [at3_pkg::IO_BITS-1:0]  out_determinant,
  output logic                                out_singular
);

  // The controller sequences phases; the datapath holds all matrices.
  at3_pkg::dp_cmd_t  cmd;
  at3_pkg::dp_stat_t stat;
  logic [at3_pkg::ELEMS-1:0][at3_pkg::IO_BITS-1:0] elem;
  logic [at3_pkg::IO_BITS-1:0] det;

  at3_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  at3_dp #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (in_op),
    .in_index     (in_index),
    .in_val_a     (in_val_a),
    .in_val_b     (in_val_b),
    .out_elem     (elem),
    .out_det      (det),
    .out_singular (out_singular)
  );

  // Elements leave in row-major order.
  assign out_e00         = elem[0];
  assign out_e01         = elem[1];
  assign out_e02         = elem[2];
  assign out_e10         = elem[3];
  assign out_e11         = elem[4];
  assign out_e12         = elem[5];
  assign out_e20         = elem[6];
  assign out_e21         = elem[7];
  assign out_e22         = elem[8];
  assign out_determinant = det;

endmodule
